[design/cwd_pkg.sv]
// cwd_pkg: shared constants and types of the codeword window detector
// no dependencies

package cwd_pkg;

    localparam int unsigned BOOK_DEPTH = 1024;
    localparam int unsigned BOOK_AW    = $clog2(BOOK_DEPTH);
    localparam int unsigned BOOK_NW    = BOOK_AW + 1;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned WIN_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned OFF_W      = 5;
    localparam int unsigned SIZE_W     = 11;

    localparam logic [3:0]        CW_PREFIX      = 4'b1110;
    localparam logic [OFF_W-1:0]  CW_MAX_OFF     = OFF_W'(7);
    localparam logic [OFF_W-1:0]  TARGET_MAX_OFF = OFF_W'(16);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_SIZE   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OFFSET,
        S_PROBE,
        S_CMP,
        S_EVENT,
        S_TARGET,
        S_DONE
    } cwd_state_t;

endpackage

[design/codeword_window_detector_top.sv]
// codeword_window_detector_top: byte window codeword search and target flag
// depends on cwd_pkg and cwd_book

// usage
//   input channel (in_valid / in_stall): one beat is either a codebook load
//   (kind = 0, entry_index / entry_value) or a received byte (kind = 1,
//   data_byte / pin_level). a load writes the codebook; a byte shifts into
//   the 32-bit window, which is then searched at offsets 7 down to 0 for a
//   1110-prefixed word present in the sorted codebook
//   output channel (out_valid / out_stall): exactly one result beat per input
//   beat, in order
//   config port (cfg_we / cfg_index / cfg_data): index 0 target word,
//   index 1 codebook size (saturates at the codebook depth)
//   sequence: a load beat goes straight to the output step. a byte beat
//   steps through the offsets, plus an address step and then a compare step
//   per binary search probe and a final probe step when the search misses,
//   for an offset whose prefix matches; then an event step, target compares
//   at offsets 16 down to 0 when no pin event occurs, and the output step.
//   the prefix fits at most two of the eight offsets
//   these steps come from the single shared shift/compare unit and the
//   codebook memory with one write port and one registered read port
//   in_stall is high from accept until the result moves to the output
//   register; the next beat is taken while a result still waits there
//   reset: window, flag and history clear, the pin detector expects high
//   first; the codebook holds no defined contents until it is loaded
//   a stalled result holds steady; the block waits in its final step until
//   the output register is free

module codeword_window_detector_top (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        kind,
    input  logic [cwd_pkg::BOOK_AW-1:0] entry_index,
    input  logic [cwd_pkg::WORD_W-1:0]  entry_value,
    input  logic [cwd_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        pin_level,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [cwd_pkg::WORD_W-1:0]  found_word,
    output logic                        event_seen,
    output logic                        target_hit,
    output logic                        flag_out,
    output logic [cwd_pkg::WORD_W-1:0]  latest_found,
    output logic [cwd_pkg::WORD_W-1:0]  previous_found,

    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [cwd_pkg::WORD_W-1:0]  cfg_data
);
    import cwd_pkg::*;

    // control state
    cwd_state_t state_reg, state_next;

    // configuration
    logic [WORD_W-1:0]  target_reg;
    logic [SIZE_W-1:0]  size_reg;

    // architectural state
    logic [WIN_W-1:0]   window_reg, window_next;
    logic               expect_reg, expect_next;
    logic               flag_reg, flag_next;
    logic [WIN_W-1:0]   hist_reg, hist_next;

    // per-beat working registers
    logic               pin_reg, pin_next;
    logic [OFF_W-1:0]   off_reg, off_next;
    logic [BOOK_NW-1:0] lo_reg, lo_next;
    logic [BOOK_NW-1:0] hi_reg, hi_next;
    logic [BOOK_NW-1:0] mid_reg, mid_next;
    logic [WORD_W-1:0]  found_reg, found_next;
    logic               event_reg, event_next;
    logic               hit_reg, hit_next;

    // output register
    logic               ovalid_reg, ovalid_next;
    logic [WORD_W-1:0]  o_found_reg, o_latest_reg, o_prev_reg;
    logic               o_event_reg, o_hit_reg, o_flag_reg;

    // shared datapath
    logic [WIN_W-1:0]   shifted;
    logic [WORD_W-1:0]  cand;
    logic [BOOK_NW:0]   mid_sum;
    logic [BOOK_NW-1:0] mid_calc;
    logic [BOOK_NW-1:0] book_n;
    logic [WORD_W-1:0]  book_rdata;
    logic [BOOK_AW-1:0] book_raddr;
    logic               book_we;
    logic               in_acc;
    logic               out_load;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!ovalid_reg || !out_stall);
    assign book_we  = in_acc && (kind == KIND_LOAD);

    // one shifter serves both the codeword offsets and the target offsets
    assign shifted  = window_reg >> off_reg;
    assign cand     = shifted[WORD_W-1:0];

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_calc = mid_sum[BOOK_NW:1];

    // codebook size saturates at the table depth
    assign book_n = (size_reg > SIZE_W'(BOOK_DEPTH)) ? BOOK_NW'(BOOK_DEPTH)
                                                     : BOOK_NW'(size_reg);
    assign book_raddr = mid_calc[BOOK_AW-1:0];

    cwd_book u_book (
        .clk   (clk),
        .we    (book_we),
        .waddr (entry_index),
        .wdata (entry_value),
        .raddr (book_raddr),
        .rdata (book_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (kind == KIND_DATA) ? S_OFFSET : S_DONE;
                end
            end
            S_OFFSET:
            begin
                if (cand[WORD_W-1:WORD_W-4] == CW_PREFIX)
                begin
                    state_next = S_PROBE;
                end
                else if (off_reg == '0)
                begin
                    state_next = S_EVENT;
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = S_CMP;
                end
                else if (off_reg == '0)
                begin
                    state_next = S_EVENT;
                end
                else
                begin
                    state_next = S_OFFSET;
                end
            end
            S_CMP:
            begin
                state_next = (cand == book_rdata) ? S_EVENT : S_PROBE;
            end
            S_EVENT:
            begin
                state_next = (pin_reg == expect_reg) ? S_DONE : S_TARGET;
            end
            S_TARGET:
            begin
                if (cand == target_reg || off_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        window_next = window_reg;
        expect_next = expect_reg;
        flag_next   = flag_reg;
        hist_next   = hist_reg;
        pin_next    = pin_reg;
        off_next    = off_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        found_next  = found_reg;
        event_next  = event_reg;
        hit_next    = hit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    found_next = '0;
                    event_next = 1'b0;
                    hit_next   = 1'b0;
                    off_next   = CW_MAX_OFF;
                    if (kind == KIND_DATA)
                    begin
                        window_next = {window_reg[WIN_W-BYTE_W-1:0], data_byte};
                        pin_next    = pin_level;
                    end
                end
            end
            S_OFFSET:
            begin
                if (cand[WORD_W-1:WORD_W-4] == CW_PREFIX)
                begin
                    lo_next = '0;
                    hi_next = book_n;
                end
                else if (off_reg != '0)
                begin
                    off_next = off_reg - OFF_W'(1);
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next = mid_calc;
                end
                else if (off_reg != '0)
                begin
                    off_next = off_reg - OFF_W'(1);
                end
            end
            S_CMP:
            begin
                if (cand == book_rdata)
                begin
                    found_next = cand;
                end
                else if (cand < book_rdata)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + BOOK_NW'(1);
                end
            end
            S_EVENT:
            begin
                if (found_reg != '0)
                begin
                    hist_next = {hist_reg[WORD_W-1:0], found_reg};
                end
                if (pin_reg == expect_reg)
                begin
                    event_next  = 1'b1;
                    expect_next = ~expect_reg;
                end
                else
                begin
                    off_next = TARGET_MAX_OFF;
                end
            end
            S_TARGET:
            begin
                if (cand == target_reg)
                begin
                    hit_next  = 1'b1;
                    flag_next = ~flag_reg;
                end
                else if (off_reg != '0)
                begin
                    off_next = off_reg - OFF_W'(1);
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // output valid: set on load, cleared when taken
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (ovalid_reg && !out_stall)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            target_reg <= '0;
            size_reg   <= '0;
            window_reg <= '0;
            expect_reg <= 1'b1;
            flag_reg   <= 1'b0;
            hist_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            window_reg <= window_next;
            expect_reg <= expect_next;
            flag_reg   <= flag_next;
            hist_reg   <= hist_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TARGET: target_reg <= cfg_data;
                    REG_SIZE:   size_reg   <= cfg_data[SIZE_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // working and payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        pin_reg   <= pin_next;
        off_reg   <= off_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        found_reg <= found_next;
        event_reg <= event_next;
        hit_reg   <= hit_next;
        if (out_load)
        begin
            o_found_reg  <= found_reg;
            o_event_reg  <= event_reg;
            o_hit_reg    <= hit_reg;
            o_flag_reg   <= flag_reg;
            o_latest_reg <= hist_reg[WORD_W-1:0];
            o_prev_reg   <= hist_reg[WIN_W-1:WORD_W];
        end
    end

    assign out_valid      = ovalid_reg;
    assign found_word     = o_found_reg;
    assign event_seen     = o_event_reg;
    assign target_hit     = o_hit_reg;
    assign flag_out       = o_flag_reg;
    assign latest_found   = o_latest_reg;
    assign previous_found = o_prev_reg;

endmodule

[design/cwd_book.sv]
// cwd_book: codebook storage, one write port and one registered read port
// depends on cwd_pkg

module cwd_book (
    input  logic                         clk,
    input  logic                         we,
    input  logic [cwd_pkg::BOOK_AW-1:0]  waddr,
    input  logic [cwd_pkg::WORD_W-1:0]   wdata,
    input  logic [cwd_pkg::BOOK_AW-1:0]  raddr,
    output logic [cwd_pkg::WORD_W-1:0]   rdata
);
    import cwd_pkg::*;

    logic [WORD_W-1:0] mem [BOOK_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[design/cwd_checker.sv]
// cwd_checker: port-level assertions for the codeword window detector
// depends on cwd_pkg; bound to codeword_window_detector_top

module cwd_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [cwd_pkg::WORD_W-1:0]  found_word,
    input  logic                        event_seen,
    input  logic                        target_hit,
    input  logic [cwd_pkg::WORD_W-1:0]  latest_found
);
    import cwd_pkg::*;

    // a stalled result beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // the block is busy right after it takes a beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again without a busy cycle");

    // a pin event suppresses the target compare
    a_hit_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target_hit |-> !event_seen)
        else $error("target hit reported together with a pin event");

    // a found word is the newest history entry
    a_hist: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (found_word != '0) |-> (latest_found == found_word))
        else $error("found word missing from history");

endmodule

bind codeword_window_detector_top cwd_checker u_cwd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found_word   (found_word),
    .event_seen   (event_seen),
    .target_hit   (target_hit),
    .latest_found (latest_found)
);
